// File: hw/rtl/svp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svp_pkg
// shared types, constants and the half-step coil table of the valve positioner
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int GEAR_W  = 3;
    localparam int POS_W   = 13;
    localparam int SPG_W   = 10;
    localparam int TEMP_W  = 12;
    localparam int DIFF_W  = TEMP_W + 1;
    localparam int PHASE_W = 3;
    localparam int COIL_W  = 4;

    localparam logic [GEAR_W-1:0] MAX_GEAR = 3'd5;

    localparam logic [SPG_W-1:0]  SPG_RESET    = 10'd350;
    localparam logic [TEMP_W-1:0] PRESET_RESET = 12'd0;

    // band edges in tenths of a degree
    localparam logic signed [DIFF_W-1:0] BAND_COLD_HI  = -13'sd65;
    localparam logic signed [DIFF_W-1:0] BAND_COLD_MID = -13'sd35;
    localparam logic signed [DIFF_W-1:0] BAND_COLD_LO  = -13'sd5;
    localparam logic signed [DIFF_W-1:0] BAND_WARM_LO  = 13'sd5;
    localparam logic signed [DIFF_W-1:0] BAND_WARM_MID = 13'sd35;
    localparam logic signed [DIFF_W-1:0] BAND_WARM_HI  = 13'sd65;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_STOP = 2'd2,
        CMD_AUTO = 2'd3
    } svp_cmd_t;

    typedef enum logic [0:0] {
        CFG_STEPS_PER_GEAR = 1'b0,
        CFG_PRESET_TEMP    = 1'b1
    } svp_cfg_idx_t;

    typedef struct packed {
        logic              hit;
        logic [GEAR_W-1:0] gear;
    } svp_band_t;

    function automatic logic [GEAR_W-1:0] sat_gear(input logic [GEAR_W-1:0] g);
        sat_gear = (g > MAX_GEAR) ? MAX_GEAR : g;
    endfunction

    function automatic logic [COIL_W-1:0] phase_coils(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] c;
        case (ph)
            3'd0:    c = 4'h1;
            3'd1:    c = 4'h3;
            3'd2:    c = 4'h2;
            3'd3:    c = 4'h6;
            3'd4:    c = 4'h4;
            3'd5:    c = 4'hC;
            3'd6:    c = 4'h8;
            3'd7:    c = 4'h9;
            default: c = 4'h0;
        endcase
        phase_coils = c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/svp_band.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svp_band
// maps temperature error to a valve gear through deadbanded bands
// ----------------------------------------------------------------------------
module svp_band
    import svp_pkg::*;
(
    input  wire logic signed [TEMP_W-1:0] temperature,
    input  wire logic signed [TEMP_W-1:0] preset_temperature,
    output svp_band_t                     band
);

    logic signed [DIFF_W-1:0] diff;
    logic [GEAR_W-1:0]        raw_gear;
    logic                     raw_hit;

    assign diff = DIFF_W'(temperature) - DIFF_W'(preset_temperature);

    always_comb
    begin
        raw_hit  = 1'b1;
        raw_gear = 3'd0;
        if (diff < BAND_COLD_HI)
        begin
            raw_gear = 3'd5;
        end
        else if (diff < BAND_COLD_MID)
        begin
            raw_gear = 3'd4;
        end
        else if (diff < BAND_COLD_LO)
        begin
            raw_gear = 3'd3;
        end
        else if (diff > BAND_WARM_HI)
        begin
            raw_gear = 3'd0;
        end
        else if (diff > BAND_WARM_MID)
        begin
            raw_gear = 3'd1;
        end
        else if (diff > BAND_WARM_LO)
        begin
            raw_gear = 3'd2;
        end
        else
        begin
            raw_hit = 1'b0;
        end
    end

    assign band.hit  = raw_hit;
    assign band.gear = sat_gear(raw_gear);

endmodule
`default_nettype wire

// File: hw/rtl/stepper_valve_positioner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_valve_positioner
// half-step stepper drive that moves a valve to one of its gear positions
// ----------------------------------------------------------------------------
// usage:
//   s_* carries command items: tuser holds the command (tick, set gear, stop,
//   automatic), tdata the requested gear and the measured temperature.
//   m_* returns one status item per command: coil pattern, moving flag,
//   reported gear, position and chosen gear, all as left by that command.
//   cfg_we/cfg_index/cfg_data write steps_per_gear (0) and
//   preset_temperature (1); write only while no item is outstanding.
// timing:
//   the state and the result register update at the accepting edge, so a
//   result appears in the cycle after its item; one item per cycle while m_tready holds.
//   the result register is the only buffer: s_tready follows
//   !m_tvalid || m_tready, so a stalled receiver holds off new items.
// reset:
//   rst_n clears all state: coils off, position and target 0, gear 0,
//   stopped, direction forward, registers to 350 and 0, no result pending.
// ----------------------------------------------------------------------------
module stepper_valve_positioner
    import svp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // requested_gear[2:0], temperature[14:3]
    input  wire logic [1:0]  s_tuser,  // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // coil_pattern[3:0], moving[4], reported_gear[7:5], position[20:8],
    // chosen_gear[23:21]
    output logic [23:0]      m_tdata
);

    logic [SPG_W-1:0]   steps_per_gear_reg,  steps_per_gear_next;
    logic [TEMP_W-1:0]  preset_temp_reg,     preset_temp_next;
    logic [PHASE_W-1:0] phase_reg,           phase_next;
    logic [COIL_W-1:0]  coil_reg,            coil_next;
    logic [POS_W-1:0]   position_reg,        position_next;
    logic [POS_W-1:0]   target_reg,          target_next;
    logic [GEAR_W-1:0]  shown_gear_reg,      shown_gear_next;
    logic [GEAR_W-1:0]  goal_gear_reg,       goal_gear_next;
    logic               run_reg,             run_next;
    logic               forward_reg,         forward_next;
    logic               out_valid_reg,       out_valid_next;
    logic [23:0]        out_data_reg,        out_data_next;

    svp_cmd_t           cmd;
    logic [GEAR_W-1:0]  req_gear;
    logic [TEMP_W-1:0]  temperature;
    logic               in_accept;
    svp_band_t          band;
    logic               do_apply;
    logic [GEAR_W-1:0]  apply_gear;
    logic [POS_W-1:0]   apply_target;

    assign cmd         = svp_cmd_t'(s_tuser);
    assign req_gear    = s_tdata[2:0];
    assign temperature = s_tdata[14:3];

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    svp_band u_band
    (
        .temperature        (temperature),
        .preset_temperature (preset_temp_reg),
        .band               (band)
    );

    assign apply_target = POS_W'(apply_gear) * POS_W'(steps_per_gear_reg);

    // configuration writes
    always_comb
    begin
        steps_per_gear_next = steps_per_gear_reg;
        preset_temp_next    = preset_temp_reg;
        if (cfg_we)
        begin
            case (svp_cfg_idx_t'(cfg_index))
                CFG_STEPS_PER_GEAR: steps_per_gear_next = cfg_data[SPG_W-1:0];
                CFG_PRESET_TEMP:    preset_temp_next    = cfg_data[TEMP_W-1:0];
                default:            steps_per_gear_next = steps_per_gear_reg;
            endcase
        end
    end

    // command execution
    always_comb
    begin
        phase_next      = phase_reg;
        coil_next       = coil_reg;
        position_next   = position_reg;
        target_next     = target_reg;
        shown_gear_next = shown_gear_reg;
        goal_gear_next  = goal_gear_reg;
        run_next        = run_reg;
        forward_next    = forward_reg;
        do_apply        = 1'b0;
        apply_gear      = sat_gear(req_gear);

        if (in_accept)
        begin
            case (cmd)
                CMD_TICK:
                begin
                    if (run_reg)
                    begin
                        if (forward_reg)
                        begin
                            position_next = position_reg + 1'b1;
                            phase_next    = phase_reg + 1'b1;
                        end
                        else
                        begin
                            position_next = position_reg - 1'b1;
                            phase_next    = phase_reg - 1'b1;
                        end
                        coil_next = phase_coils(phase_next);
                        if (position_next == target_reg)
                        begin
                            run_next        = 1'b0;
                            shown_gear_next = goal_gear_reg;
                        end
                    end
                end
                CMD_SET:
                begin
                    do_apply = 1'b1;
                end
                CMD_STOP:
                begin
                    target_next = position_reg;
                    run_next    = 1'b0;
                end
                CMD_AUTO:
                begin
                    do_apply   = band.hit;
                    apply_gear = band.gear;
                end
                default:
                begin
                    do_apply = 1'b0;
                end
            endcase

            if (do_apply)
            begin
                goal_gear_next  = apply_gear;
                shown_gear_next = apply_gear;
                target_next     = apply_target;
                if (apply_target > position_reg)
                begin
                    forward_next = 1'b1;
                    run_next     = 1'b1;
                end
                else if (apply_target < position_reg)
                begin
                    forward_next = 1'b0;
                    run_next     = 1'b1;
                end
                else
                begin
                    run_next = 1'b0;
                end
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {shown_gear_next, position_next, shown_gear_next,
                              run_next, coil_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_per_gear_reg <= SPG_RESET;
            preset_temp_reg    <= PRESET_RESET;
            phase_reg          <= '0;
            coil_reg           <= '0;
            position_reg       <= '0;
            target_reg         <= '0;
            shown_gear_reg     <= '0;
            goal_gear_reg      <= '0;
            run_reg            <= 1'b0;
            forward_reg        <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            steps_per_gear_reg <= steps_per_gear_next;
            preset_temp_reg    <= preset_temp_next;
            phase_reg          <= phase_next;
            coil_reg           <= coil_next;
            position_reg       <= position_next;
            target_reg         <= target_next;
            shown_gear_reg     <= shown_gear_next;
            goal_gear_reg      <= goal_gear_next;
            run_reg            <= run_next;
            forward_reg        <= forward_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // a running motor never sits on its target
    a_run_off_target: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (position_reg != target_reg))
        else $error("motor running while at target");

    // coils are either off or match the current phase
    a_coil_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (coil_reg != '0) |-> (coil_reg == phase_coils(phase_reg)))
        else $error("coil pattern out of step with phase");

    // position moves only on an accepted item
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(position_reg))
        else $error("position changed without an item");

    // gears stay within range
    a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
        (shown_gear_reg <= MAX_GEAR) && (goal_gear_reg <= MAX_GEAR))
        else $error("gear beyond maximum");

    // an item taken while a result waits untaken would overwrite it
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && out_valid_reg) |-> m_tready)
        else $error("result overwritten before delivery");
`endif

endmodule
`default_nettype wire
